@@ rtl/assert_macros.svh @@
// Assertion shorthands used by the checker file.
// Each macro wraps one concurrent assertion that is clocked on the rising edge
// and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define MVT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Antecedent now, consequent in the next cycle.
`define MVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mvt_pkg.sv @@
`default_nettype none

package mvt_pkg;

	localparam int NUM_COMP = 4;
	localparam int COMP_W   = 32;
	localparam int PROD_W   = 2 * COMP_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int COL_W    = 2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_XFORM = 1'b1;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [COL_W-1:0]         col_idx_t;

	// Everything an item carries from one cell to the next.
	typedef struct packed {
		logic                   action;
		col_idx_t               column;
		comp_t [NUM_COMP-1:0]   comp;
		acc_t  [NUM_COMP-1:0]   acc;
	} chain_t;

endpackage

`default_nettype wire

@@ rtl/mvt_if.sv @@
`default_nettype none

interface mvt_req_if import mvt_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     action;
	col_idx_t column;
	comp_t    comp_x;
	comp_t    comp_y;
	comp_t    comp_z;
	comp_t    comp_w;

	modport source (output valid, action, column, comp_x, comp_y, comp_z, comp_w,
		input ready);
	modport sink (input valid, action, column, comp_x, comp_y, comp_z, comp_w,
		output ready);
endinterface

interface mvt_rsp_if import mvt_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t out_x;
	comp_t out_y;
	comp_t out_z;
	comp_t out_w;

	modport source (output valid, out_x, out_y, out_z, out_w, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

`default_nettype wire

@@ rtl/mvt_cell.sv @@
`default_nettype none

// One matrix column. A load for this column captures it; every other item
// gets this column times its own vector component added to the row sums.
module mvt_cell import mvt_pkg::*; #(
	parameter int unsigned CELL_IDX = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   up_valid,
	input  wire chain_t up,
	output logic        down_valid,
	output chain_t      down
);

	localparam col_idx_t MY_COL = col_idx_t'(CELL_IDX);

	comp_t [NUM_COMP-1:0] col_q;
	logic                 valid_s1;
	chain_t               item_s1;
	prod_t [NUM_COMP-1:0] prod_s1;
	logic                 valid_s2;
	chain_t               item_s2;
	logic                 take_col;

	assign take_col = en && up_valid && (up.action == ACT_LOAD) && (up.column == MY_COL);

	always_ff @(posedge clk) begin
		if (take_col) begin
			col_q <= up.comp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= up;
			for (int r = 0; r < NUM_COMP; r++) begin
				prod_s1[r] <= prod_t'(col_q[r]) * prod_t'(up.comp[CELL_IDX]);
			end
			item_s2.action <= item_s1.action;
			item_s2.column <= item_s1.column;
			item_s2.comp   <= item_s1.comp;
			for (int r = 0; r < NUM_COMP; r++) begin
				item_s2.acc[r] <= $signed(item_s1.acc[r]) + acc_t'($signed(prod_s1[r]));
			end
		end
	end

	assign down_valid = valid_s2;
	assign down       = item_s2;

endmodule

`default_nettype wire

@@ rtl/mvt_out_stage.sv @@
`default_nettype none

// Scales the row sums back to the component format, clamps them, and holds
// the result until it is taken.
module mvt_out_stage import mvt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_valid,
	input  wire chain_t item,
	output logic        valid_q,
	output comp_t [NUM_COMP-1:0] res_q
);

	localparam acc_t POS_LIM = {{(ACC_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
	localparam acc_t NEG_LIM = {{(ACC_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

	function automatic comp_t shift_sat(input acc_t s);
		acc_t sh;
		sh = s >>> FRAC_BITS;
		if (sh > POS_LIM) begin
			return POS_LIM[COMP_W-1:0];
		end else if (sh < NEG_LIM) begin
			return NEG_LIM[COMP_W-1:0];
		end
		return sh[COMP_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid && (item.action == ACT_XFORM);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < NUM_COMP; r++) begin
				res_q[r] <= shift_sat($signed(item.acc[r]));
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mat4_vector_transform.sv @@
`default_nettype none

// 4x4 matrix times 4-vector in signed fixed point with FRAC_BITS fraction bits.
// A load transaction (action 0) writes one column of the matrix from its four
// components and returns nothing; a transform transaction (action 1) returns
// the stored matrix times the vector it carries, each row sum shifted right by
// FRAC_BITS (rounding toward minus infinity) and clamped to 32 bits. The block
// takes one transaction per clock while the chain is not paused. A transform's
// result passes through the chain of four column cells, each of which
// registers its four multiplies and then their sum with the running row sums,
// followed by the scaling and output register. The whole chain moves forward
// together, so it pauses only while a finished result sits in the output
// register and the downstream side is not ready. Loads travel down the chain
// in order with the transforms, so a transform always uses exactly the columns
// loaded before it. Columns must be loaded before they are used; the matrix
// holds no defined value out of reset.
module mat4_vector_transform import mvt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mvt_req_if.sink    req,
	mvt_rsp_if.source  rsp
);

	logic                 en;
	logic                 link_valid [NUM_COMP+1];
	chain_t               link       [NUM_COMP+1];
	comp_t [NUM_COMP-1:0] res;

	// The chain advances whenever the output register is empty or being drained.
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// Feed the first cell straight from the request transaction with the row
	// sums starting at zero.
	assign link_valid[0]     = req.valid;
	assign link[0].action    = req.action;
	assign link[0].column    = req.column;
	assign link[0].comp[0]   = req.comp_x;
	assign link[0].comp[1]   = req.comp_y;
	assign link[0].comp[2]   = req.comp_z;
	assign link[0].comp[3]   = req.comp_w;
	assign link[0].acc       = '0;

	for (genvar c = 0; c < NUM_COMP; c++) begin : g_cell
		mvt_cell #(
			.CELL_IDX (c)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.up_valid   (link_valid[c]),
			.up         (link[c]),
			.down_valid (link_valid[c+1]),
			.down       (link[c+1])
		);
	end

	mvt_out_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (link_valid[NUM_COMP]),
		.item     (link[NUM_COMP]),
		.valid_q  (rsp.valid),
		.res_q    (res)
	);

	assign rsp.out_x = res[0];
	assign rsp.out_y = res[1];
	assign rsp.out_z = res[2];
	assign rsp.out_w = res[3];

endmodule

`default_nettype wire

@@ rtl/mvt_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module mvt_checker import mvt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic req_action,
	input wire logic rsp_valid,
	input wire logic rsp_ready
);

	// A result that is not taken stays offered.
	`MVT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// Requests are refused only while a result waits for the downstream side.
	`MVT_ASSERT(a_ready_link, clk, arst_n, req_ready == (!rsp_valid || rsp_ready), "request ready does not follow output state")

	// With no stall before it, a new result comes from a transform transaction
	// accepted at the head of the chain.
	`MVT_ASSERT(a_latency, clk, arst_n, !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready && (req_action == ACT_XFORM), 9), "result without a matching transform")

endmodule

bind mat4_vector_transform mvt_checker u_mvt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready)
);

`default_nettype wire
